### sv/stli_pkg.sv
// Package for the sorted table linear interpolator: shared types, codes and
// constants. No dependencies.
`timescale 1ns / 1ps

package stli_pkg;

   localparam int DATA_W      = 32;
   localparam int INDEX_W     = 13;
   localparam int ENTRIES_W   = 14;
   localparam logic [ENTRIES_W-1:0] ENTRIES_RESET = 14'd2;

   // quotient is below 2^33, so 33 restoring steps cover it
   localparam int DIV_STEPS   = 33;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH_CHK,
      ST_SEARCH_CMP,
      ST_FETCH,
      ST_SETUP,
      ST_MUL,
      ST_DIV,
      ST_FINISH
   } state_type;

   // what the table read port looks at
   typedef enum logic [1:0] {
      RD_MID,
      RD_UPPER,
      RD_LOWER
   } rd_sel_type;

   typedef struct packed {
      logic       start;
      logic       load;
      rd_sel_type rd_sel;
      logic       search_step;
      logic       fetch_upper;
      logic       setup;
      logic       mul;
      logic       div_step;
      logic       out_load;
      logic       out_oor;
   } cmd_type;

   typedef struct packed {
      logic search_more;
      logic bracket_oor;
      logic out_free;
   } status_type;

endpackage

### sv/stli_ctrl.sv
// Controller for the sorted table linear interpolator: sequences search,
// fetch, multiply and divide. Depends on stli_pkg.
`timescale 1ns / 1ps

module stli_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_func,
   output logic                req_stall,
   input  stli_pkg::status_type status,
   output stli_pkg::cmd_type   cmd
);

   stli_pkg::state_type state_ff, state_in;
   logic [stli_pkg::DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= stli_pkg::ST_IDLE;
         div_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      div_cnt_in = div_cnt_ff;
      cmd        = '0;
      cmd.rd_sel = stli_pkg::RD_MID;
      req_stall  = 1'b1;
      unique case (state_ff)
         stli_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_func == stli_pkg::FUNC_QUERY) begin
                  cmd.start = 1'b1;
                  state_in  = stli_pkg::ST_SEARCH_CHK;
               end else begin
                  cmd.load = 1'b1;
               end
            end
         end
         stli_pkg::ST_SEARCH_CHK: begin
            if (status.search_more) begin
               cmd.rd_sel = stli_pkg::RD_MID;
               state_in   = stli_pkg::ST_SEARCH_CMP;
            end else if (status.bracket_oor) begin
               state_in = stli_pkg::ST_FINISH;
            end else begin
               cmd.rd_sel = stli_pkg::RD_UPPER;
               state_in   = stli_pkg::ST_FETCH;
            end
         end
         stli_pkg::ST_SEARCH_CMP: begin
            cmd.search_step = 1'b1;
            state_in        = stli_pkg::ST_SEARCH_CHK;
         end
         stli_pkg::ST_FETCH: begin
            cmd.fetch_upper = 1'b1;
            cmd.rd_sel      = stli_pkg::RD_LOWER;
            state_in        = stli_pkg::ST_SETUP;
         end
         stli_pkg::ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = stli_pkg::ST_MUL;
         end
         stli_pkg::ST_MUL: begin
            cmd.mul    = 1'b1;
            div_cnt_in = '0;
            state_in   = stli_pkg::ST_DIV;
         end
         stli_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (div_cnt_ff == stli_pkg::DIV_CNT_W'(stli_pkg::DIV_STEPS - 1)) begin
               state_in = stli_pkg::ST_FINISH;
            end else begin
               div_cnt_in = div_cnt_ff + 1'b1;
            end
         end
         stli_pkg::ST_FINISH: begin
            // bracket_oor still reflects the finished search here
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_oor  = status.bracket_oor;
               state_in     = stli_pkg::ST_IDLE;
            end
         end
         default: state_in = stli_pkg::ST_IDLE;
      endcase
   end

endmodule

### sv/stli_datapath.sv
// Datapath for the sorted table linear interpolator: breakpoint memories,
// search bounds, multiplier, restoring divider, result register. Depends on stli_pkg.
`timescale 1ns / 1ps

module stli_datapath #(
   parameter int TABLE_DEPTH = 8192
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  stli_pkg::cmd_type                     cmd,
   output stli_pkg::status_type                  status,
   input  logic                                  csr_valid,
   input  logic [stli_pkg::ENTRIES_W-1:0]        csr_entries_used,
   input  logic [stli_pkg::INDEX_W-1:0]          req_entry_index,
   input  logic signed [stli_pkg::DATA_W-1:0]    req_entry_key,
   input  logic signed [stli_pkg::DATA_W-1:0]    req_entry_value,
   input  logic signed [stli_pkg::DATA_W-1:0]    req_query_key,
   input  logic                                  rsp_stall,
   output logic                                  rsp_valid,
   output logic signed [stli_pkg::DATA_W-1:0]    rsp_interp_value,
   output logic                                  rsp_off_table
);

   localparam int AW    = $clog2(TABLE_DEPTH);
   localparam int NW    = $clog2(TABLE_DEPTH + 1);
   localparam int IW    = (AW > stli_pkg::INDEX_W) ? AW : stli_pkg::INDEX_W;
   localparam int DW    = stli_pkg::DATA_W;

   logic [DW-1:0] key_mem [TABLE_DEPTH];
   logic [DW-1:0] val_mem [TABLE_DEPTH];

   logic [stli_pkg::ENTRIES_W-1:0] entries_used_ff;
   logic signed [DW-1:0] q_ff;
   logic [NW-1:0]        n_ff, lo_ff, hi_ff;
   logic [DW-1:0]        key_rd_ff, val_rd_ff;
   logic [DW-1:0]        x1_ff, y1_ff, y0_ff;
   logic [DW-1:0]        d_ff, b_ff;
   logic                 neg_ff;
   logic [DW:0]          mag_ff;
   logic [DW-1:0]        rem_ff;
   logic [DW:0]          sh_ff, quo_ff;
   logic                 rsp_valid_ff;
   logic signed [DW-1:0] rsp_value_ff;
   logic                 rsp_oor_ff;

   logic [NW-1:0]        mid, lower, n_sat;
   logic [IW-1:0]        idx_wide;
   logic [AW-1:0]        wr_addr, rd_addr;
   logic                 wr_en;
   logic signed [DW:0]   d_diff, b_diff, dy;
   logic [2*DW-1:0]      product;
   logic [DW:0]          trial;
   logic                 trial_ge;
   logic                 rem_nz;
   logic signed [DW+2:0] y0_ext, quo_ext, sum, f;

   // ---- configuration ----
   always_ff @(posedge clock) begin
      if (reset) begin
         entries_used_ff <= stli_pkg::ENTRIES_RESET;
      end else if (csr_valid) begin
         entries_used_ff <= csr_entries_used;
      end
   end

   assign n_sat = (32'(entries_used_ff) > 32'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH)
                                                           : NW'(entries_used_ff);

   // ---- table memories ----
   assign idx_wide = IW'(req_entry_index);
   assign wr_addr  = idx_wide[AW-1:0];
   assign wr_en    = cmd.load && (32'(req_entry_index) < 32'(TABLE_DEPTH));

   assign mid   = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign lower = lo_ff - 1'b1;

   always_comb begin
      unique case (cmd.rd_sel)
         stli_pkg::RD_MID:   rd_addr = mid[AW-1:0];
         stli_pkg::RD_UPPER: rd_addr = lo_ff[AW-1:0];
         stli_pkg::RD_LOWER: rd_addr = lower[AW-1:0];
         default:            rd_addr = mid[AW-1:0];
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr] <= req_entry_key;
         val_mem[wr_addr] <= req_entry_value;
      end
      key_rd_ff <= key_mem[rd_addr];
      val_rd_ff <= val_mem[rd_addr];
   end

   // ---- upper-bound search ----
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         q_ff  <= req_query_key;
         n_ff  <= n_sat;
         lo_ff <= '0;
         hi_ff <= n_sat;
      end else if (cmd.search_step) begin
         if ($signed(key_rd_ff) <= q_ff) begin
            lo_ff <= mid + 1'b1;
         end else begin
            hi_ff <= mid;
         end
      end
   end

   assign status.search_more = lo_ff < hi_ff;
   assign status.bracket_oor = (lo_ff == '0) || (lo_ff >= n_ff);
   assign status.out_free    = !rsp_valid_ff || !rsp_stall;

   // ---- operand setup: d = x1-x0, b = q-x0, |y1-y0| ----
   assign d_diff = {x1_ff[DW-1], x1_ff} - {key_rd_ff[DW-1], key_rd_ff};
   assign b_diff = {q_ff[DW-1], q_ff} - {key_rd_ff[DW-1], key_rd_ff};
   assign dy     = {y1_ff[DW-1], y1_ff} - {val_rd_ff[DW-1], val_rd_ff};

   // |dy| reaches 2^32 only with a zero low word, so the top bit selects a shift
   assign product = mag_ff[DW] ? {b_ff, {DW{1'b0}}}
                               : (2*DW)'(mag_ff[DW-1:0]) * (2*DW)'(b_ff);

   assign trial    = {rem_ff, sh_ff[DW]};
   assign trial_ge = trial >= {1'b0, d_ff};

   always_ff @(posedge clock) begin
      if (cmd.fetch_upper) begin
         x1_ff <= key_rd_ff;
         y1_ff <= val_rd_ff;
      end
      if (cmd.setup) begin
         y0_ff  <= val_rd_ff;
         d_ff   <= d_diff[DW-1:0];
         b_ff   <= b_diff[DW-1:0];
         neg_ff <= dy[DW];
         mag_ff <= dy[DW] ? (DW+1)'(-dy) : (DW+1)'(dy);
      end
      if (cmd.mul) begin
         // product < d * 2^33, so the top part already sits below d
         rem_ff <= {1'b0, product[2*DW-1:DW+1]};
         sh_ff  <= product[DW:0];
         quo_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= trial_ge ? DW'(trial - {1'b0, d_ff}) : trial[DW-1:0];
         sh_ff  <= {sh_ff[DW-1:0], 1'b0};
         quo_ff <= {quo_ff[DW-1:0], trial_ge};
      end
   end

   // ---- result: y0 +/- quotient, truncated toward zero ----
   assign rem_nz  = rem_ff != '0;
   assign y0_ext  = (DW+3)'($signed(y0_ff));
   assign quo_ext = (DW+3)'(quo_ff);

   always_comb begin
      if (neg_ff) begin
         sum = y0_ext - quo_ext - (DW+3)'(rem_nz);
      end else begin
         sum = y0_ext + quo_ext;
      end
      f = (sum < 0 && rem_nz) ? sum + (DW+3)'(1) : sum;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_oor_ff   <= cmd.out_oor;
         rsp_value_ff <= cmd.out_oor ? '0 : f[DW-1:0];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_interp_value = rsp_value_ff;
   assign rsp_off_table    = rsp_oor_ff;

   // ---- checks ----
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid_ff)
      else $error("result register not valid after load");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp_valid_ff && rsp_stall))
      else $error("stalled result overwritten");

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_oor_ff |-> rsp_value_ff == '0)
      else $error("out-of-range result carries a value");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> rem_ff < d_ff)
      else $error("partial remainder not below divisor");

endmodule

### sv/sorted_table_linear_interpolator.sv
// Sorted table linear interpolator, top level: controller plus datapath.
// Depends on stli_pkg, stli_ctrl and stli_datapath.
//
// Holds up to TABLE_DEPTH breakpoints (key, value) in signed Q16.16. A load
// beat (func 0) writes one pair and returns nothing. A query beat (func 1)
// binary-searches the first csr_entries_used entries for the first key above
// the query key and returns the linear interpolation between that entry and
// the one before it, truncated toward zero, or a zero value with
// rsp_off_table set when the query is below the first key or at or above the
// last key in use. Keys must be loaded in increasing order, and only loaded
// entries may fall under the search. One query is in flight at a time. A
// query makes at most s = ceil(log2(n+1)) search steps over the single
// registered table read port (n the entries in use; s = 14 for 8192
// entries), then fetches, multiplies and runs the bit-serial divider of 33
// restoring steps. An out-of-range query skips the fetch, multiply and
// divide. The block returns to idle once the result register takes the
// result. The result register lets the next beat be accepted while a result
// waits on rsp_stall. The user writes csr_entries_used only while the block
// is idle; the block itself does not enforce this.
`timescale 1ns / 1ps

module sorted_table_linear_interpolator #(
   parameter int TABLE_DEPTH = 8192
) (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [stli_pkg::ENTRIES_W-1:0]        csr_entries_used,

   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_func,
   input  logic [stli_pkg::INDEX_W-1:0]          req_entry_index,
   input  logic signed [stli_pkg::DATA_W-1:0]    req_entry_key,
   input  logic signed [stli_pkg::DATA_W-1:0]    req_entry_value,
   input  logic signed [stli_pkg::DATA_W-1:0]    req_query_key,

   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [stli_pkg::DATA_W-1:0]    rsp_interp_value,
   output logic                                  rsp_off_table
);

   stli_pkg::cmd_type    cmd;
   stli_pkg::status_type status;

   assign csr_ready = 1'b1;

   stli_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   stli_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_valid        (csr_valid && csr_ready),
      .csr_entries_used (csr_entries_used),
      .req_entry_index  (req_entry_index),
      .req_entry_key    (req_entry_key),
      .req_entry_value  (req_entry_value),
      .req_query_key    (req_query_key),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_interp_value (rsp_interp_value),
      .rsp_off_table    (rsp_off_table)
   );

endmodule
